// ===== rtl/core/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Types, codes and coil pattern table shared by the full-step sequencer.
// ----------------------------------------------------------------------------
package stp_pkg;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_MOVE = 1'b1
   } stp_op_type;

   typedef enum logic {
      CSR_STEPS_PER_REV = 1'b0,
      CSR_STEP_DELAY    = 1'b1
   } stp_csr_type;

   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned REV_WIDTH   = 16;

   localparam logic [REV_WIDTH-1:0] STEPS_PER_REV_RESET = 16'd200;
   localparam logic [31:0]          STEP_DELAY_RESET    = 32'd1250;

   // bit 3 = A, bit 2 = AN, bit 1 = B, bit 0 = BN
   typedef logic [3:0] stp_coil_type;

   typedef struct packed {
      logic busy;
      logic rejected;
   } stp_flags_type;

   localparam stp_coil_type CW_PATTERNS [4] = '{4'h9, 4'h5, 4'h6, 4'hA};

   function automatic stp_coil_type stp_pattern(input logic [1:0] phase, input logic cw);
      return cw ? CW_PATTERNS[phase] : CW_PATTERNS[2'd3 - phase];
   endfunction

endpackage

// ===== rtl/core/stp_input_stage.sv =====
// ----------------------------------------------------------------------------
// stp_input_stage
// Input register for request words; hands a word on when the result
// register can take it.
// ----------------------------------------------------------------------------
module stp_input_stage (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  stp_pkg::stp_op_type                   req_op,
   input  logic signed [stp_pkg::COUNT_WIDTH-1:0] req_step_count,
   input  logic                                  out_ready,
   output logic                                  item_fire,
   output stp_pkg::stp_op_type                   item_op,
   output logic signed [stp_pkg::COUNT_WIDTH-1:0] item_step_count
);
   import stp_pkg::*;

   logic                          valid_ff, valid_in;
   stp_op_type                    op_ff;
   logic signed [COUNT_WIDTH-1:0] count_ff;
   logic                          load;

   assign item_fire       = valid_ff & out_ready;
   assign req_stall       = valid_ff & ~out_ready;
   assign load            = req_valid & ~req_stall;
   assign item_op         = op_ff;
   assign item_step_count = count_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!valid_ff || item_fire) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff    <= req_op;
         count_ff <= req_step_count;
      end
   end

endmodule

// ===== rtl/core/stp_motion.sv =====
// ----------------------------------------------------------------------------
// stp_motion
// Configuration registers, move state, hold counter, phase sequencing and
// position wrap; gives the result of the word being handed on.
// ----------------------------------------------------------------------------
module stp_motion #(
   parameter int unsigned POS_WIDTH   = 16,
   parameter int unsigned DELAY_WIDTH = 20,
   parameter int unsigned CSR_WIDTH   = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  stp_pkg::stp_csr_type                  csr_index,
   input  logic [CSR_WIDTH-1:0]                  csr_write_data,
   input  logic                                  item_fire,
   input  stp_pkg::stp_op_type                   item_op,
   input  logic signed [stp_pkg::COUNT_WIDTH-1:0] item_step_count,
   output stp_pkg::stp_coil_type                 coil_out,
   output logic [POS_WIDTH-1:0]                  position_out,
   output stp_pkg::stp_flags_type                flags_out
);
   import stp_pkg::*;

   localparam int unsigned EXT_WIDTH = ((POS_WIDTH > REV_WIDTH) ? POS_WIDTH : REV_WIDTH) + 1;

   logic [REV_WIDTH-1:0]   steps_per_rev_ff;
   logic [DELAY_WIDTH-1:0] step_delay_ff;

   logic                   moving_ff, moving_in;
   logic                   cw_ff, cw_in;
   logic [COUNT_WIDTH-1:0] steps_left_ff, steps_left_in;
   logic [1:0]             phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0] hold_ff, hold_in;
   logic [POS_WIDTH-1:0]   shaft_ff, shaft_in;
   stp_coil_type           coil_ff, coil_in;

   logic                   rejected;
   logic                   neg;
   logic [COUNT_WIDTH-1:0] count_u;
   logic [COUNT_WIDTH-1:0] mag;
   logic [DELAY_WIDTH:0]   held;
   logic [EXT_WIDTH-1:0]   shaft_ext, lim_ext, pos_sum;
   logic [POS_WIDTH-1:0]   pos_next;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_rev_ff <= STEPS_PER_REV_RESET;
         step_delay_ff    <= STEP_DELAY_RESET[DELAY_WIDTH-1:0];
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STEPS_PER_REV: steps_per_rev_ff <= csr_write_data[REV_WIDTH-1:0];
            CSR_STEP_DELAY:    step_delay_ff    <= csr_write_data[DELAY_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // position after a finished step, with wrap
   always_comb begin
      shaft_ext = {{(EXT_WIDTH-POS_WIDTH){1'b0}}, shaft_ff};
      lim_ext   = {{(EXT_WIDTH-REV_WIDTH){1'b0}}, steps_per_rev_ff};
      pos_sum   = cw_ff ? (shaft_ext - 1'b1) : (shaft_ext + 1'b1);
      if (cw_ff && shaft_ff == '0) begin
         pos_next = lim_ext[POS_WIDTH-1:0];
      end else if (pos_sum > lim_ext) begin
         pos_next = pos_sum[POS_WIDTH-1:0] - lim_ext[POS_WIDTH-1:0];
      end else begin
         pos_next = pos_sum[POS_WIDTH-1:0];
      end
   end

   always_comb begin
      moving_in     = moving_ff;
      cw_in         = cw_ff;
      steps_left_in = steps_left_ff;
      phase_in      = phase_ff;
      hold_in       = hold_ff;
      shaft_in      = shaft_ff;
      coil_in       = coil_ff;
      rejected      = 1'b0;
      neg           = item_step_count[COUNT_WIDTH-1];
      count_u       = item_step_count;
      mag           = neg ? ({COUNT_WIDTH{1'b0}} - count_u) : count_u;
      held          = {1'b0, hold_ff} + 1'b1;
      if (item_fire) begin
         case (item_op)
            OP_MOVE: begin
               if (moving_ff) begin
                  rejected = 1'b1;
               end else begin
                  cw_in = ~neg;
                  if (mag != '0) begin
                     steps_left_in = mag;
                     moving_in     = 1'b1;
                     phase_in      = 2'd0;
                     hold_in       = '0;
                     coil_in       = stp_pattern(2'd0, ~neg);
                  end
               end
            end
            OP_TICK: begin
               if (moving_ff) begin
                  if (held >= {1'b0, step_delay_ff}) begin
                     hold_in = '0;
                     if (phase_ff == 2'd3) begin
                        shaft_in      = pos_next;
                        steps_left_in = steps_left_ff - 1'b1;
                        phase_in      = 2'd0;
                        if (steps_left_ff == {{(COUNT_WIDTH-1){1'b0}}, 1'b1}) begin
                           moving_in = 1'b0;
                        end else begin
                           coil_in = stp_pattern(2'd0, cw_ff);
                        end
                     end else begin
                        phase_in = phase_ff + 1'b1;
                        coil_in  = stp_pattern(phase_ff + 1'b1, cw_ff);
                     end
                  end else begin
                     hold_in = held[DELAY_WIDTH-1:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moving_ff     <= 1'b0;
         cw_ff         <= 1'b1;
         steps_left_ff <= '0;
         phase_ff      <= 2'd0;
         hold_ff       <= '0;
         shaft_ff      <= '0;
         coil_ff       <= '0;
      end else begin
         moving_ff     <= moving_in;
         cw_ff         <= cw_in;
         steps_left_ff <= steps_left_in;
         phase_ff      <= phase_in;
         hold_ff       <= hold_in;
         shaft_ff      <= shaft_in;
         coil_ff       <= coil_in;
      end
   end

   assign coil_out       = coil_in;
   assign position_out   = shaft_in;
   assign flags_out.busy     = moving_in;
   assign flags_out.rejected = rejected;

`ifndef SYNTHESIS
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |-> (phase_ff == 2'd0 && hold_ff == '0))
      else $error("phase or hold counter nonzero while idle");

   a_moving_steps: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> steps_left_ff != '0)
      else $error("moving with no steps left");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (item_fire && item_op == OP_MOVE && moving_ff) |=>
         ($stable(steps_left_ff) && $stable(phase_ff) && $stable(hold_ff) && $stable(cw_ff)))
      else $error("rejected move changed the state");
`endif

endmodule

// ===== rtl/core/stp_output_stage.sv =====
// ----------------------------------------------------------------------------
// stp_output_stage
// Result register; holds a word while the receiver stalls.
// ----------------------------------------------------------------------------
module stp_output_stage #(
   parameter int unsigned POS_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  stp_pkg::stp_coil_type  coil_in,
   input  logic [POS_WIDTH-1:0]   position_in,
   input  stp_pkg::stp_flags_type flags_in,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_coil_a,
   output logic                   rsp_coil_an,
   output logic                   rsp_coil_b,
   output logic                   rsp_coil_bn,
   output logic [POS_WIDTH-1:0]   rsp_position,
   output logic                   rsp_busy_res,
   output logic                   rsp_rejected
);
   import stp_pkg::*;

   logic             valid_ff, valid_in;
   stp_coil_type     coil_ff;
   logic [POS_WIDTH-1:0] position_ff;
   stp_flags_type    flags_ff;

   assign out_ready = ~valid_ff | ~rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         coil_ff     <= coil_in;
         position_ff <= position_in;
         flags_ff    <= flags_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_coil_a   = coil_ff[3];
   assign rsp_coil_an  = coil_ff[2];
   assign rsp_coil_b   = coil_ff[1];
   assign rsp_coil_bn  = coil_ff[0];
   assign rsp_position = position_ff;
   assign rsp_busy_res = flags_ff.busy;
   assign rsp_rejected = flags_ff.rejected;

endmodule

// ===== rtl/core/stepper_full_step_sequencer_top.sv =====
// path: a request word is held in the input register, then its result in the result register
// throughput: one word per cycle while rsp_stall is low; request and result registers decouple the sides
// each word passes the step logic once between the two registers
// reset: synchronous, clears move state, coils off, position 0
// reset: steps_per_rev 200, step_delay 1250, no clearing pass
// ----------------------------------------------------------------------------
// stepper_full_step_sequencer_top
// Full-step bipolar stepper sequencer: moves, tick-driven coil patterns and
// shaft position with wrap.
// ----------------------------------------------------------------------------
module stepper_full_step_sequencer_top #(
   parameter int unsigned POS_WIDTH   = 16,
   parameter int unsigned DELAY_WIDTH = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  stp_pkg::stp_csr_type                  csr_index,
   input  logic [((DELAY_WIDTH > stp_pkg::REV_WIDTH) ? DELAY_WIDTH
                  : stp_pkg::REV_WIDTH)-1:0]       csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  stp_pkg::stp_op_type                   req_op,
   input  logic signed [stp_pkg::COUNT_WIDTH-1:0] req_step_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_coil_a,
   output logic                                  rsp_coil_an,
   output logic                                  rsp_coil_b,
   output logic                                  rsp_coil_bn,
   output logic [POS_WIDTH-1:0]                  rsp_position,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_rejected
);
   import stp_pkg::*;

   localparam int unsigned CSR_WIDTH = (DELAY_WIDTH > REV_WIDTH) ? DELAY_WIDTH : REV_WIDTH;

   logic                          out_ready;
   logic                          item_fire;
   stp_op_type                    item_op;
   logic signed [COUNT_WIDTH-1:0] item_step_count;
   stp_coil_type                  coil;
   logic [POS_WIDTH-1:0]          position;
   stp_flags_type                 flags;

   stp_input_stage u_input (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_step_count (req_step_count),
      .out_ready      (out_ready),
      .item_fire      (item_fire),
      .item_op        (item_op),
      .item_step_count(item_step_count)
   );

   stp_motion #(
      .POS_WIDTH  (POS_WIDTH),
      .DELAY_WIDTH(DELAY_WIDTH),
      .CSR_WIDTH  (CSR_WIDTH)
   ) u_motion (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .item_fire       (item_fire),
      .item_op         (item_op),
      .item_step_count (item_step_count),
      .coil_out        (coil),
      .position_out    (position),
      .flags_out       (flags)
   );

   stp_output_stage #(
      .POS_WIDTH(POS_WIDTH)
   ) u_output (
      .clock       (clock),
      .reset       (reset),
      .load        (item_fire),
      .coil_in     (coil),
      .position_in (position),
      .flags_in    (flags),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_coil_a  (rsp_coil_a),
      .rsp_coil_an (rsp_coil_an),
      .rsp_coil_b  (rsp_coil_b),
      .rsp_coil_bn (rsp_coil_bn),
      .rsp_position(rsp_position),
      .rsp_busy_res(rsp_busy_res),
      .rsp_rejected(rsp_rejected)
   );

endmodule
